@@ hdl/tcon_pkg.sv @@
// Package: shared constants, flag structs and the SGR colour table for the text console.
package tcon_pkg;

  localparam int TCON_COLUMNS   = 80;
  localparam int TCON_ROWS      = 25;
  localparam int TCON_SEQ_DEPTH = 16;

  localparam logic [15:0] BLANK_RESET  = 16'h0F20;
  localparam logic [15:0] BLANK_SCROLL = 16'h1F20;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;

  localparam logic [3:0] FORE_DEFAULT = 4'hF;
  localparam logic [3:0] BACK_DEFAULT = 4'h0;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       active;
    logic [3:0] fore;
    logic [3:0] back;
  } sgr_stat_t;

  typedef struct packed {
    logic write_cell;
    logic scroll;
  } cur_flags_t;

  function automatic logic [3:0] colour_map(input logic [2:0] code);
    logic [3:0] c;
    unique case (code)
      3'd0: c = 4'h0;
      3'd1: c = 4'h4;
      3'd2: c = 4'h2;
      3'd3: c = 4'hE;
      3'd4: c = 4'h1;
      3'd5: c = 4'h5;
      3'd6: c = 4'h3;
      3'd7: c = 4'hF;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/tcon_if.sv @@
// Interfaces: request and response channels of the text console.
interface tcon_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  modport source (output valid, command, char_code, cell_index, input ready);
  modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcon_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [15:0] cell_data;
  modport source (output valid, cursor_position, cell_data, input ready);
  modport sink   (input valid, cursor_position, cell_data, output ready);
endinterface

@@ hdl/text_console_with_ansi_colour_unit.sv @@
// Top level: text console sequencer around the screen cell RAM.
// Put: the accepting beat moves the sequencer to S_DONE, which loads the result into the output register;
// a new item is taken only after that load, and a result held by the receiver stalls the next item.
// Read: adds an S_READ state for the registered RAM read; out-of-range reads skip the RAM.
// Scroll put: adds a row-copy pass and a fill of the bottom row.
// Reset: a clearing pass writes blank 0x0F20 to all ROWS*COLUMNS cells before the first item
// is accepted; cursor, colours and escape state reset at once.
module text_console_with_ansi_colour_unit #(
  parameter int COLUMNS   = tcon_pkg::TCON_COLUMNS,
  parameter int ROWS      = tcon_pkg::TCON_ROWS,
  parameter int SEQ_DEPTH = tcon_pkg::TCON_SEQ_DEPTH
) (
  input logic        clk,
  input logic        rst,
  tcon_req_if.sink   req,
  tcon_rsp_if.source rsp
);
  import tcon_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [AW-1:0] cnt;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [10:0]   pend_pos;
  logic [15:0]   pend_data;
  logic          out_valid;
  logic [10:0]   out_pos;
  logic [15:0]   out_data;

  logic          accept;
  logic          is_put;
  logic          consume;
  logic          out_free;
  logic          rd_in_range;
  logic [31:0]   idx32;
  logic [31:0]   ridx32;
  logic [31:0]   pos32;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  sgr_stat_t     sgr;
  cur_flags_t    cflags;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_put    = (req.command == CMD_PUT);
  assign consume   = sgr.active || (req.char_code == CH_ESC);
  assign out_free  = !out_valid || rsp.ready;

  assign ridx32      = {21'd0, req.cell_index};
  assign rd_in_range = (ridx32 < 32'(CELLS));
  assign idx32       = 32'(cur_row) * 32'(COLUMNS) + 32'(cur_col);
  // reads and escape bytes leave the cursor where it is
  assign pos32       = (consume || !is_put) ? idx32 :
                       32'(row_next) * 32'(COLUMNS) + 32'(col_next);

  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_pos;
  assign rsp.cell_data       = out_data;

  tcon_sgr #(.SEQ_DEPTH(SEQ_DEPTH)) u_sgr (
    .clk       (clk),
    .rst       (rst),
    .put       (accept && is_put),
    .char_code (req.char_code),
    .stat      (sgr)
  );

  tcon_cursor #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cursor (
    .char_code (req.char_code),
    .col       (cur_col),
    .row       (cur_row),
    .col_next  (col_next),
    .row_next  (row_next),
    .flags     (cflags)
  );

  tcon_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = ram_rdata;
    ram_raddr = ridx32[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
      end
      S_IDLE: begin
        ram_we    = accept && is_put && !consume && cflags.write_cell;
        ram_waddr = idx32[AW-1:0];
        ram_wdata = {sgr.back, sgr.fore, req.char_code};
      end
      S_COPY: begin
        // read one row ahead, write the beat read last cycle one row up
        ram_raddr = cnt + AW'(COLUMNS);
        ram_we    = (cnt != '0);
        ram_waddr = cnt - AW'(1);
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_SCROLL;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            pend_pos  <= pos32[10:0];
            pend_data <= 16'h0000;
            if (!is_put) begin
              state <= rd_in_range ? S_READ : S_DONE;
            end else if (!consume) begin
              cur_col <= col_next;
              cur_row <= row_next;
              cnt     <= '0;
              state   <= cflags.scroll ? S_COPY : S_DONE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          pend_data <= ram_rdata;
          state     <= S_DONE;
        end
        S_COPY: begin
          // hold cnt at the fill start once the last copy beat is written
          if (cnt == AW'(CELLS - COLUMNS)) begin
            state <= S_FILL;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_FILL: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_pos   <= pend_pos;
            out_data  <= pend_data;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_stray_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !accept) |-> !ram_we)
    else $error("cell write while idle without a beat");
  a_copy_trails_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && $past(state) == S_COPY && cnt != '0)
      |-> (ram_waddr + AW'(COLUMNS)) == $past(ram_raddr))
    else $error("scroll copy write does not trail its read");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid && state == S_IDLE)
    else $error("finished result not loaded");
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    cur_row < RW'(ROWS))
    else $error("cursor row out of range");
endmodule

@@ hdl/tcon_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/tcon_sgr.sv @@
// SGR escape parser: tracks escape mode, parses colour codes per beat, holds colours.
module tcon_sgr #(
  parameter int SEQ_DEPTH = tcon_pkg::TCON_SEQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  put,
  input  logic [7:0]            char_code,
  output tcon_pkg::sgr_stat_t   stat
);
  import tcon_pkg::*;

  localparam int LW = $clog2(SEQ_DEPTH + 1);

  logic          active;
  logic [3:0]    fore;
  logic [3:0]    back;
  logic [3:0]    pfore;
  logic [3:0]    pback;
  logic [LW-1:0] len;
  logic          bracket;
  logic [1:0]    code_cnt;
  logic [7:0]    code_first;
  logic          digit_ok;

  assign digit_ok = (char_code[7:3] == 5'b00110);

  assign stat.active = active;
  assign stat.fore   = fore;
  assign stat.back   = back;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      fore       <= FORE_DEFAULT;
      back       <= BACK_DEFAULT;
      pfore      <= FORE_DEFAULT;
      pback      <= BACK_DEFAULT;
      len        <= '0;
      bracket    <= 1'b0;
      code_cnt   <= 2'd0;
      code_first <= 8'h00;
    end else if (put) begin
      if (active) begin
        if (char_code == CH_M) begin
          active <= 1'b0;
          // commit only a sequence that opened with a bracket
          if (bracket) begin
            fore <= pfore;
            back <= pback;
          end
        end else if (len < LW'(SEQ_DEPTH)) begin
          len <= len + LW'(1);
          if (len == '0) begin
            bracket <= (char_code == CH_LBR);
          end else if (char_code == CH_SEMI) begin
            code_cnt <= 2'd0;
          end else begin
            unique case (code_cnt)
              2'd0: begin
                code_first <= char_code;
                code_cnt   <= 2'd1;
                if (char_code == CH_0) begin
                  pfore <= FORE_DEFAULT;
                  pback <= BACK_DEFAULT;
                end
              end
              2'd1: begin
                code_cnt <= 2'd2;
                if (digit_ok && code_first == CH_3) begin
                  pfore <= colour_map(char_code[2:0]);
                end
                if (digit_ok && code_first == CH_4) begin
                  pback <= colour_map(char_code[2:0]);
                end
              end
              default: code_cnt <= code_cnt;
            endcase
          end
        end
      end else if (char_code == CH_ESC) begin
        active   <= 1'b1;
        len      <= '0;
        bracket  <= 1'b0;
        code_cnt <= 2'd0;
        pfore    <= fore;
        pback    <= back;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(SEQ_DEPTH))
    else $error("sequence length past depth");
  a_idle_colours_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(active) |-> $stable(fore) && $stable(back))
    else $error("colours changed outside a sequence");
  a_end_leaves: assert property (@(posedge clk) disable iff (rst)
    (put && active && char_code == CH_M) |=> !active)
    else $error("sequence end did not leave escape mode");
endmodule

@@ hdl/tcon_cursor.sv @@
// Cursor next-state logic: control bytes, printable advance, column wrap, scroll request.
module tcon_cursor #(
  parameter int COLUMNS = tcon_pkg::TCON_COLUMNS,
  parameter int ROWS    = tcon_pkg::TCON_ROWS
) (
  input  logic [7:0]                  char_code,
  input  logic [$clog2(COLUMNS)-1:0]  col,
  input  logic [$clog2(ROWS)-1:0]     row,
  output logic [$clog2(COLUMNS)-1:0]  col_next,
  output logic [$clog2(ROWS)-1:0]     row_next,
  output tcon_pkg::cur_flags_t        flags
);
  import tcon_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int TW  = $clog2(COLUMNS + 8);
  localparam int RW  = $clog2(ROWS);
  localparam int RTW = $clog2(ROWS + 1);

  logic [TW-1:0]  tc;
  logic [RTW-1:0] tr;
  logic           printable;

  assign printable = !char_code[7] && (char_code[6:5] != 2'b00);

  always_comb begin
    tc = {{(TW-CW){1'b0}}, col};
    tr = {{(RTW-RW){1'b0}}, row};
    priority if (char_code == CH_BS) begin
      if (tc != '0) tc = tc - TW'(1);
    end else if (char_code == CH_TAB) begin
      tc = (tc + TW'(8)) & ~TW'(7);
    end else if (char_code == CH_CR) begin
      tc = '0;
    end else if (char_code == CH_LF) begin
      tc = '0;
      tr = tr + RTW'(1);
    end else if (printable) begin
      tc = tc + TW'(1);
    end else begin
      tc = tc;
    end
    if (tc >= TW'(COLUMNS)) begin
      tc = '0;
      tr = tr + RTW'(1);
    end
    flags.write_cell = printable;
    flags.scroll     = (tr >= RTW'(ROWS));
    col_next = tc[CW-1:0];
    row_next = flags.scroll ? RW'(ROWS - 1) : tr[RW-1:0];
  end
endmodule

@@ bench/tb_text_console_with_ansi_colour_unit.sv @@
// Testbench for the text console: directed and random byte streams checked against a shadow screen.
module tb_text_console_with_ansi_colour_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcon_pkg::*;

  localparam int CELLS       = TCON_COLUMNS * TCON_ROWS;
  localparam int ITEM_TARGET = 2000;
  localparam int QUIET_ITEMS = 400;
  localparam int STALL_PCT   = 19;
  localparam int MAX_REPORTS = 100;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7F;

  // SGR colour number to VGA attribute nibble
  localparam logic [3:0] SGR_TO_VGA [8] = '{4'h0, 4'h4, 4'h2, 4'hE, 4'h1, 4'h5, 4'h3, 4'hF};

  typedef struct packed {
    logic [10:0] cursor;
    logic [15:0] cell_word;
  } console_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcon_req_if req_ch ();
  tcon_rsp_if rsp_ch ();

  text_console_with_ansi_colour_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the console state
  logic [15:0]  screen_shadow [CELLS] = '{default: BLANK_RESET};
  int unsigned  cur_col = 0;
  int unsigned  cur_row = 0;
  logic [3:0]   pen_fore = FORE_DEFAULT;
  logic [3:0]   pen_back = BACK_DEFAULT;
  bit           esc_active = 1'b0;
  logic [7:0]   sgr_bytes [TCON_SEQ_DEPTH] = '{default: 8'h00};
  int unsigned  sgr_count = 0;

  console_rsp_t awaited_rsp [$];
  int           error_count = 0;
  int           items_sent = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_stalls_on = 1'b1;
  int           rx_hold_cycles = 0;

  function automatic void decode_sgr_code(int unsigned first_pos, int unsigned end_pos);
    logic [7:0] lead;
    logic [7:0] digit;
    bit         digit_ok;
    lead  = (first_pos < end_pos && first_pos < TCON_SEQ_DEPTH) ? sgr_bytes[first_pos] : 8'h00;
    digit = (first_pos + 1 < end_pos && first_pos + 1 < TCON_SEQ_DEPTH) ?
            sgr_bytes[first_pos + 1] : 8'h00;
    digit_ok = (digit >= CH_0) && (digit <= CH_0 + 8'd7);
    if (lead == CH_3) begin
      if (digit_ok) pen_fore = SGR_TO_VGA[digit[2:0]];
    end else if (lead == CH_4) begin
      if (digit_ok) pen_back = SGR_TO_VGA[digit[2:0]];
    end else if (lead == CH_0) begin
      pen_fore = FORE_DEFAULT;
      pen_back = BACK_DEFAULT;
    end
  endfunction

  function automatic console_rsp_t predict_console(logic cmd, logic [7:0] ch,
                                                   logic [10:0] idx);
    console_rsp_t r;
    int unsigned  code_start;
    r.cell_word = '0;
    if (cmd == CMD_READ) begin
      if (idx < CELLS) r.cell_word = screen_shadow[idx];
    end else if (esc_active) begin
      if (ch == CH_M) begin
        esc_active = 1'b0;
        if (sgr_count != 0 && sgr_bytes[0] == CH_LBR) begin
          code_start = 1;
          for (int unsigned p = 1; p < sgr_count; p++) begin
            if (sgr_bytes[p] == CH_SEMI) begin
              decode_sgr_code(code_start, p);
              code_start = p + 1;
            end
          end
          decode_sgr_code(code_start, sgr_count);
        end
      end else if (sgr_count < TCON_SEQ_DEPTH) begin
        sgr_bytes[sgr_count] = ch;
        sgr_count++;
      end
    end else if (ch == CH_ESC) begin
      sgr_bytes  = '{default: 8'h00};
      sgr_count  = 0;
      esc_active = 1'b1;
    end else begin
      if (ch == CH_BS) begin
        if (cur_col > 0) cur_col--;
      end else if (ch == CH_TAB) begin
        cur_col = (cur_col + 8) & ~32'd7;
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else if (ch == CH_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
        screen_shadow[cur_row * TCON_COLUMNS + cur_col] = {pen_back, pen_fore, ch};
        cur_col++;
      end
      if (cur_col >= TCON_COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      // scroll up one row and blank the new bottom row
      if (cur_row >= TCON_ROWS) begin
        for (int i = 0; i < CELLS - TCON_COLUMNS; i++)
          screen_shadow[i] = screen_shadow[i + TCON_COLUMNS];
        for (int i = CELLS - TCON_COLUMNS; i < CELLS; i++)
          screen_shadow[i] = BLANK_SCROLL;
        cur_row = TCON_ROWS - 1;
      end
    end
    r.cursor = 11'(cur_row * TCON_COLUMNS + cur_col);
    return r;
  endfunction

  task automatic drive_console_beat(input logic cmd, input logic [7:0] ch,
                                    input logic [10:0] idx);
    bit ignored;
    while (tx_gaps_on && $urandom_range(99) < STALL_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.char_code  <= ch;
    req_ch.cell_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ignored = (cmd == CMD_PUT) && !esc_active &&
              !(ch inside {CH_BS, CH_TAB, CH_CR, CH_LF, CH_ESC, [PRINT_LO:PRINT_HI]});
    awaited_rsp.push_back(predict_console(cmd, ch, idx));
    if (!ignored) items_sent++;
  endtask

  task automatic put_char(input logic [7:0] ch);
    drive_console_beat(CMD_PUT, ch, 11'($urandom));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    drive_console_beat(CMD_READ, 8'($urandom), idx);
  endtask

  function automatic logic [7:0] any_but_m();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == CH_M) ? CH_SEMI : b;
  endfunction

  // build one escape sequence, mostly well-formed SGR with random codes
  task automatic send_sgr_sequence();
    logic [7:0] seq_q [$];
    int         variant;
    int         n_codes;
    int         kind;
    variant = $urandom_range(99);
    seq_q.push_back(CH_ESC);
    if (variant < 75) begin
      seq_q.push_back(CH_LBR);
      n_codes = $urandom_range(1, 4);
      for (int c = 0; c < n_codes; c++) begin
        if (c != 0) seq_q.push_back(CH_SEMI);
        kind = $urandom_range(9);
        case (kind)
          0, 1, 2: begin
            seq_q.push_back(CH_3);
            seq_q.push_back(CH_0 + 8'($urandom_range(7)));
          end
          3, 4, 5: begin
            seq_q.push_back(CH_4);
            seq_q.push_back(CH_0 + 8'($urandom_range(7)));
          end
          6: seq_q.push_back(CH_0);
          7: begin
            // colour lead with a random or missing digit
            seq_q.push_back($urandom_range(1) ? CH_3 : CH_4);
            if ($urandom_range(1)) seq_q.push_back(any_but_m());
          end
          8: begin
            seq_q.push_back(any_but_m());
            seq_q.push_back(any_but_m());
          end
          default: begin
            // empty code or one with trailing digits
            if ($urandom_range(1)) begin
              seq_q.push_back($urandom_range(1) ? CH_3 : CH_4);
              seq_q.push_back(CH_0 + 8'($urandom_range(7)));
              seq_q.push_back(CH_0 + 8'($urandom_range(9)));
            end
          end
        endcase
      end
    end else if (variant < 83) begin
      seq_q.push_back(any_but_m());
      seq_q.push_back(CH_3);
      seq_q.push_back(CH_0 + 8'($urandom_range(7)));
    end else if (variant < 90) begin
      // overrun the buffer; later codes must be dropped
      seq_q.push_back(CH_LBR);
      repeat ($urandom_range(14, 22)) seq_q.push_back(any_but_m());
      seq_q.push_back(CH_SEMI);
      seq_q.push_back(CH_4);
      seq_q.push_back(CH_0 + 8'($urandom_range(7)));
    end else if (variant < 95) begin
      if ($urandom_range(1)) seq_q.push_back(CH_LBR);
    end else begin
      seq_q.push_back(CH_ESC);
      seq_q.push_back(CH_LBR);
      seq_q.push_back(CH_3);
      seq_q.push_back(CH_0 + 8'($urandom_range(7)));
    end
    seq_q.push_back(CH_M);
    foreach (seq_q[i]) put_char(seq_q[i]);
  endtask

  task automatic test_directed_edges();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    put_char(CH_BS);
    put_char(PRINT_LO);
    put_char(PRINT_HI);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(CH_TAB);
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_ESC);
    put_char(CH_LBR);
    put_char(CH_3);
    put_char(CH_0 + 8'd1);
    put_char(CH_SEMI);
    put_char(CH_4);
    put_char(CH_0 + 8'd4);
    put_char(CH_M);
    put_char("A");
    put_char(CH_ESC);
    put_char(CH_LBR);
    put_char(CH_0);
    put_char(CH_M);
    put_char(CH_LF);
    read_cell(11'd0);
    read_cell(11'd1);
  endtask

  task automatic test_scroll_and_tab_wrap();
    put_char(CH_CR);
    repeat (TCON_ROWS + 1) put_char(CH_LF);
    put_char("Z");
    // tabs run off the last column and scroll again
    repeat (TCON_COLUMNS / 8) put_char(CH_TAB);
    read_cell(11'(CELLS - 2 * TCON_COLUMNS));
    read_cell(11'(CELLS - TCON_COLUMNS));
    read_cell(11'(CELLS - 1));
  endtask

  task automatic test_output_backpressure();
    rx_hold_cycles = 500;
    repeat (60) put_char(8'($urandom_range(PRINT_LO, PRINT_HI)));
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [7:0] ctl;
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      tx_gaps_on   = (items_sent >= QUIET_ITEMS);
      rx_stalls_on = (items_sent >= QUIET_ITEMS);
      pick = $urandom_range(99);
      if (pick < 40) begin
        put_char(8'($urandom_range(PRINT_LO, PRINT_HI)));
      end else if (pick < 46) begin
        case ($urandom_range(3))
          0: ctl = CH_BS;
          1: ctl = CH_TAB;
          2: ctl = CH_CR;
          default: ctl = CH_LF;
        endcase
        put_char(ctl);
      end else if (pick < 56) begin
        put_char(8'($urandom));
      end else if (pick < 80) begin
        if ($urandom_range(9) == 0)
          read_cell(11'($urandom_range(CELLS, 2047)));
        else
          read_cell(11'($urandom_range(CELLS - 1)));
      end else begin
        send_sgr_sequence();
      end
    end
  endtask

  // response side: random stalls, plus a long hold-off when a test asks for one
  initial begin : rsp_drain
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        rsp_ch.ready <= !(rx_stalls_on && $urandom_range(99) < STALL_PCT);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    console_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $error("unexpected beat: cursor_position %0d cell_data %h",
                 rsp_ch.cursor_position, rsp_ch.cell_data);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.cursor_position !== want.cursor) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("cursor_position: expected %0d actual %0d",
                   want.cursor, rsp_ch.cursor_position);
        end
        if (rsp_ch.cell_data !== want.cell_word) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("cell_data: expected %h actual %h", want.cell_word, rsp_ch.cell_data);
        end
      end
    end
  end

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_PUT;
    req_ch.char_code  <= 8'h00;
    req_ch.cell_index <= 11'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_scroll_and_tab_wrap();
    test_output_backpressure();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      error_count++;
      $error("%0d responses never arrived", awaited_rsp.size());
    end
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hold the whole run to a fixed budget
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ text_console_with_ansi_colour_unit.f @@
hdl/tcon_pkg.sv
hdl/tcon_if.sv
hdl/tcon_ram.sv
hdl/tcon_sgr.sv
hdl/tcon_cursor.sv
hdl/text_console_with_ansi_colour_unit.sv
bench/tb_text_console_with_ansi_colour_unit.sv
